@@ sv/postfix_expression_evaluator_assert.svh @@
// Assertion macros shared by the postfix evaluator RTL.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// Property checked at every aclk edge outside reset.
`define PEF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define PEF_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

`endif

@@ sv/pef_pkg.sv @@
// Shared types and constants of the postfix expression evaluator.
package pef_pkg;

    localparam int DATA_W = 32;

    // Expression characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Value of a pop from an empty stack
    localparam logic [DATA_W-1:0] VAL_EMPTY = '1;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ sv/postfix_expression_evaluator.sv @@
// Postfix expression evaluator: stack sequencer around the operand memory.
//
// Input channel s_*: one expression character per item; s_tlast marks the
// last character of an expression. Result channel m_*: one item per
// expression, the final popped value with its sticky error flags.
// Work per input item, set by the sequencer around the operand memory:
// a digit is pushed as it is accepted; an operator passes through accept,
// two pops through the registered memory read, execute and push; a
// division by a nonzero divisor also waits for the 32-step divider. The
// last character adds the final pop, and its result is written to the
// output register once the final memory read returns.
// Reset empties the stack and clears the flags; the memory needs no
// clearing pass since only entries below the fill count are read.
// A stalled receiver holds the result in the output register; the next
// expression is accepted meanwhile and only its final pop waits for the
// output register to drain.
module postfix_expression_evaluator import pef_pkg::*; #(
    parameter int STACK_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic [2:0]  m_tuser    // [0] underflow, [1] overflow, [2] div_zero
);

`include "postfix_expression_evaluator_assert.svh"

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_POP1  = 7'b0000010,
        ST_POP2  = 7'b0000100,
        ST_EXEC  = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_FINAL = 7'b0100000,
        ST_FREAD = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [7:0]        ch_reg, ch_next;
    logic              last_reg, last_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              uf_reg, uf_next;
    logic              of_reg, of_next;
    logic              dz_reg, dz_next;
    logic [DATA_W-1:0] v1_reg, v1_next;
    logic [DATA_W-1:0] v2_reg, v2_next;
    logic [DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [2:0]        m_tuser_reg, m_tuser_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic              accept;
    logic              push_en;
    logic [DATA_W-1:0] push_val;
    logic [CW-1:0]     cnt_m1;
    logic [CW-1:0]     cnt_m2;
    logic              has1;
    logic              has2;
    logic              full;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] dif;
    logic [DATA_W-1:0] prod;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    assign cnt_m1 = cnt_reg - CW'(1);
    assign cnt_m2 = cnt_reg - CW'(2);
    assign has1   = (cnt_reg != '0);
    assign has2   = (cnt_reg >= CW'(2));
    assign full   = (cnt_reg >= DEPTH_C);

    // Arithmetic on the two popped operands
    assign sum  = v2_reg + v1_reg;
    assign dif  = v2_reg - v1_reg;
    assign prod = v2_reg * v1_reg;

    pef_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pef_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Sequencer: reads and writes to the memory never share a cycle
    always_comb begin
        state_next    = state_reg;
        ch_next       = ch_reg;
        last_next     = last_reg;
        cnt_next      = cnt_reg;
        uf_next       = uf_reg;
        of_next       = of_reg;
        dz_next       = dz_reg;
        v1_next       = v1_reg;
        v2_next       = v2_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ram_re        = 1'b0;
        ram_raddr     = cnt_m1[AW-1:0];
        push_en       = 1'b0;
        push_val      = '0;
        div_req.start    = 1'b0;
        div_req.dividend = v2_reg;
        div_req.divisor  = v1_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ch_next   = s_tdata;
                    last_next = s_tlast;
                    if (s_tdata inside {[CH_ZERO:CH_NINE]}) begin
                        push_en    = 1'b1;
                        push_val   = DATA_W'(s_tdata - CH_ZERO);
                        state_next = s_tlast ? ST_FINAL : ST_IDLE;
                    end else begin
                        ram_re     = has1;
                        state_next = ST_POP1;
                    end
                end
            end
            ST_POP1: begin
                v1_next    = has1 ? ram_rdata : VAL_EMPTY;
                ram_re     = has2;
                ram_raddr  = cnt_m2[AW-1:0];
                uf_next    = uf_reg || !has2;
                state_next = ST_POP2;
            end
            ST_POP2: begin
                v2_next    = has2 ? ram_rdata : VAL_EMPTY;
                cnt_next   = has2 ? cnt_m2 : '0;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = last_reg ? ST_FINAL : ST_IDLE;
                case (ch_reg)
                    CH_PLUS: begin
                        push_en  = 1'b1;
                        push_val = sum;
                    end
                    CH_MINUS: begin
                        push_en  = 1'b1;
                        push_val = dif;
                    end
                    CH_STAR: begin
                        push_en  = 1'b1;
                        push_val = prod;
                    end
                    CH_SLASH: begin
                        if (v1_reg == '0) begin
                            dz_next = 1'b1;
                            push_en = 1'b1;
                        end else begin
                            div_req.start = 1'b1;
                            state_next    = ST_DIV;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    push_en    = 1'b1;
                    push_val   = div_rsp.quotient;
                    state_next = last_reg ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FINAL: begin
                // wait until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    ram_re     = has1;
                    state_next = ST_FREAD;
                end
            end
            ST_FREAD: begin
                m_tdata_next  = has1 ? ram_rdata : VAL_EMPTY;
                m_tuser_next  = {dz_reg, of_reg, uf_reg || !has1};
                m_tvalid_next = 1'b1;
                cnt_next      = '0;
                uf_next       = 1'b0;
                of_next       = 1'b0;
                dz_next       = 1'b0;
                state_next    = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Push, dropped when the stack is full
        ram_we    = 1'b0;
        ram_waddr = cnt_reg[AW-1:0];
        ram_wdata = push_val;
        if (push_en) begin
            if (full) begin
                of_next = 1'b1;
            end else begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + CW'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            uf_reg       <= 1'b0;
            of_reg       <= 1'b0;
            dz_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            uf_reg       <= uf_next;
            of_reg       <= of_next;
            dz_reg       <= dz_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ch_reg      <= ch_next;
        last_reg    <= last_next;
        v1_reg      <= v1_next;
        v2_reg      <= v2_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks
    `PEF_NEVER(a_cnt_range, cnt_reg > DEPTH_C, "stack count beyond depth")
    `PEF_NEVER(a_ram_rw, ram_we && ram_re, "memory read and write in one cycle")
    `PEF_ASSERT(a_out_free, (state_reg == ST_FREAD) |-> !m_tvalid_reg, "result overwrites item")
    `PEF_ASSERT(a_div_owner, div_rsp.done |-> (state_reg == ST_DIV), "divider done while not waiting")
    `PEF_ASSERT(a_final_clear, (state_reg == ST_FREAD) |=> (cnt_reg == '0 && !uf_reg), "no clear")

endmodule

@@ sv/pef_stack_ram.sv @@
// Operand stack memory: one write port, one registered read port.
module pef_stack_ram import pef_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/pef_divider.sv @@
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
module pef_divider import pef_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        step_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic              neg_reg;

    logic              na;
    logic              nb;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              fits;

    assign na = req.dividend[DATA_W-1];
    assign nb = req.divisor[DATA_W-1];

    // Restoring step on the magnitudes
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = !diff[DATA_W];

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (req.start && !busy_reg) begin
            quo_reg <= na ? (DATA_W'(0) - req.dividend) : req.dividend;
            dvs_reg <= nb ? (DATA_W'(0) - req.divisor) : req.divisor;
            rem_reg <= '0;
            neg_reg <= na ^ nb;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

@@ sim/postfix_expression_evaluator_test.sv @@
// Self-checking testbench of the postfix evaluator: directed rows and cases, then random expressions.
module postfix_expression_evaluator_test;
    import pef_pkg::*;

    localparam int DEPTH        = 64;
    localparam int RANDOM_ITEMS = 430;
    localparam int DRAIN_CYCLES = 60;

    // Bytes that are neither digits nor operators
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TOP = 8'hFF;

    // One result item: {value, underflow, overflow, div_zero}
    typedef struct packed {
        logic [31:0] value;
        logic        underflow;
        logic        overflow;
        logic        div_zero;
    } result_t;

    // Directed row: character, last flag, and an optional typed-in result
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        result_t    want;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    // Shadow of the operand stack and sticky flags
    logic [31:0] stack_mem [DEPTH];
    int          fill;
    bit          uf_seen;
    bit          ov_seen;
    bit          dz_seen;

    result_t     pending_results [$];
    int          mismatch_count;
    int          items_sent;
    bit          no_idle;

    row_t directed_rows [0:24] = '{
        '{CH_NUL,             1'b1, 1'b1, '{VAL_EMPTY,    1'b1, 1'b0, 1'b0}},
        '{CH_TOP,             1'b1, 1'b1, '{VAL_EMPTY,    1'b1, 1'b0, 1'b0}},
        '{CH_NINE,            1'b0, 1'b0, '0},
        '{CH_NINE,            1'b0, 1'b0, '0},
        '{CH_STAR,            1'b1, 1'b1, '{32'd81,       1'b0, 1'b0, 1'b0}},
        '{CH_ZERO + 8'd7,     1'b0, 1'b0, '0},
        '{CH_ZERO,            1'b0, 1'b0, '0},
        '{CH_SLASH,           1'b1, 1'b1, '{32'd0,        1'b0, 1'b0, 1'b1}},
        '{CH_ZERO + 8'd3,     1'b0, 1'b0, '0},
        '{CH_ZERO + 8'd5,     1'b0, 1'b0, '0},
        '{CH_MINUS,           1'b1, 1'b1, '{32'hFFFFFFFE, 1'b0, 1'b0, 1'b0}},
        '{CH_NINE,            1'b0, 1'b0, '0},
        '{CH_PLUS,            1'b1, 1'b1, '{32'd8,        1'b1, 1'b0, 1'b0}},
        '{CH_ZERO + 8'd8,     1'b0, 1'b0, '0},
        '{CH_ZERO + 8'd3,     1'b0, 1'b0, '0},
        '{CH_SLASH,           1'b0, 1'b0, '0},
        '{CH_ZERO + 8'd6,     1'b0, 1'b0, '0},
        '{CH_MINUS,           1'b1, 1'b0, '0},
        '{CH_ZERO,            1'b1, 1'b1, '{32'd0,        1'b0, 1'b0, 1'b0}},
        '{CH_NINE,            1'b1, 1'b1, '{32'd9,        1'b0, 1'b0, 1'b0}},
        '{CH_ZERO,            1'b0, 1'b0, '0},
        '{CH_ZERO + 8'd7,     1'b0, 1'b0, '0},
        '{CH_MINUS,           1'b0, 1'b0, '0},
        '{CH_ZERO + 8'd2,     1'b0, 1'b0, '0},
        '{CH_SLASH,           1'b1, 1'b0, '0}
    };

    postfix_expression_evaluator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] ch
        .s_tlast  (s_tlast),   // is_last
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [31:0] value
        .m_tuser  (m_tuser)    // [0] underflow, [1] overflow, [2] div_zero
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Stack push; a full stack drops the value
    function automatic void push_value(logic [31:0] v);
        if (fill >= DEPTH) begin
            ov_seen = 1'b1;
        end else begin
            stack_mem[fill] = v;
            fill++;
        end
    endfunction

    // Stack pop; an empty stack yields all ones
    function automatic logic [31:0] pop_value();
        if (fill == 0) begin
            uf_seen = 1'b1;
            return VAL_EMPTY;
        end
        fill--;
        return stack_mem[fill];
    endfunction

    // Apply one character; returns 1 with the result when it ends an expression
    function automatic bit evaluate_char(logic [7:0] ch, bit last, output result_t res);
        logic [31:0] v1, v2, mag_a, mag_b, quot;
        bit          neg_a, neg_b;
        res = '0;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            push_value({24'd0, ch - CH_ZERO});
        end else begin
            v1 = pop_value();
            v2 = pop_value();
            case (ch)
                CH_PLUS:  push_value(v2 + v1);
                CH_MINUS: push_value(v2 - v1);
                CH_STAR:  push_value(v2 * v1);
                CH_SLASH: begin
                    if (v1 == 32'd0) begin
                        dz_seen = 1'b1;
                        push_value(32'd0);
                    end else begin
                        // magnitude divide, sign fixed up afterwards (truncates toward zero)
                        neg_a = v2[31];
                        neg_b = v1[31];
                        mag_a = neg_a ? -v2 : v2;
                        mag_b = neg_b ? -v1 : v1;
                        quot  = mag_a / mag_b;
                        push_value((neg_a != neg_b) ? -quot : quot);
                    end
                end
                default: ;
            endcase
        end
        if (!last)
            return 1'b0;
        res.value     = pop_value();
        res.underflow = uf_seen;
        res.overflow  = ov_seen;
        res.div_zero  = dz_seen;
        fill    = 0;
        uf_seen = 1'b0;
        ov_seen = 1'b0;
        dz_seen = 1'b0;
        return 1'b1;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Send one item after a random gap (none in no_idle mode); record the expected result on acceptance
    task automatic send_char(input logic [7:0] ch, input bit last, input bit typed,
                             input result_t want);
        int      gap;
        result_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (evaluate_char(ch, last, predicted))
            pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic send_digit(input int d, input bit last);
        send_char(CH_ZERO + 8'(d), last, 1'b0, '0);
    endtask

    // Valid postfix expression with random digits and operators
    task automatic send_wellformed(input int operands);
        int         left, depth;
        logic [7:0] ch;
        left  = operands;
        depth = 0;
        while (left > 0 || depth > 1) begin
            if (left > 0 && (depth < 2 || $urandom_range(0, 1) == 1)) begin
                ch = CH_ZERO + 8'($urandom_range(0, 9));
                left--;
                depth++;
            end else begin
                case ($urandom_range(0, 3))
                    0: ch = CH_PLUS;
                    1: ch = CH_MINUS;
                    2: ch = CH_STAR;
                    default: ch = CH_SLASH;
                endcase
                depth--;
            end
            send_char(ch, left == 0 && depth == 1, 1'b0, '0);
        end
    endtask

    // Broken sequence: any byte, or digits and operators in random order
    task automatic send_jumble(input int len, input bit any_byte);
        logic [7:0] ch;
        for (int i = 0; i < len; i++) begin
            if (any_byte)
                ch = 8'($urandom_range(0, 255));
            else if ($urandom_range(0, 1) == 1)
                ch = CH_ZERO + 8'($urandom_range(0, 9));
            else begin
                case ($urandom_range(0, 3))
                    0: ch = CH_PLUS;
                    1: ch = CH_MINUS;
                    2: ch = CH_STAR;
                    default: ch = CH_SLASH;
                endcase
            end
            send_char(ch, i == len - 1, 1'b0, '0);
        end
    endtask

    // Sender goes idle until every expected result has come out
    task automatic wait_drained();
        if (pending_results.size() != 0) begin
            s_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(posedge aclk);
        end
    endtask

    // Stimulus
    initial begin
        int target, expr_count, kind;
        s_tvalid       <= 1'b0;
        s_tdata        <= 8'd0;
        s_tlast        <= 1'b0;
        aresetn        <= 1'b0;
        fill           = 0;
        uf_seen        = 1'b0;
        ov_seen        = 1'b0;
        dz_seen        = 1'b0;
        mismatch_count = 0;
        items_sent     = 0;
        no_idle        = 1'b0;
        expr_count     = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_char(directed_rows[i].ch, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want);

        // Overfill the stack, then combine the top two
        repeat (DEPTH + 2) send_digit($urandom_range(0, 9), 1'b0);
        send_char(CH_PLUS, 1'b1, 1'b0, '0);

        // Build the most negative value (2 * 8^10) and divide it by -1
        send_digit(2, 1'b0);
        repeat (10) begin
            send_digit(8, 1'b0);
            send_char(CH_STAR, 1'b0, 1'b0, '0);
        end
        send_digit(0, 1'b0);
        send_digit(1, 1'b0);
        send_char(CH_MINUS, 1'b0, 1'b0, '0);
        send_char(CH_SLASH, 1'b1, 1'b0, '0);

        // Hold off until everything queued has come out
        wait_drained();

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            no_idle = ((expr_count / 15) % 4) == 3;
            kind    = $urandom_range(0, 19);
            if (kind < 2)
                send_wellformed($urandom_range(6, 24));
            else if (kind < 14)
                send_wellformed($urandom_range(1, 6));
            else if (kind < 16)
                send_jumble($urandom_range(1, 8), 1'b1);
            else if (kind < 19)
                send_jumble($urandom_range(1, 10), 1'b0);
            else if ($urandom_range(0, 3) == 0) begin
                repeat (DEPTH + $urandom_range(0, 3)) send_digit($urandom_range(0, 9), 1'b0);
                send_wellformed(1);
            end else
                send_wellformed($urandom_range(10, 16));
            expr_count++;
            if (expr_count % 40 == 0)
                wait_drained();
        end

        no_idle = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Result side: random stalls (none in no_idle mode), compare each item with the oldest expectation
    initial begin
        int      gap;
        result_t want;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual value 0x%h flags %b",
                         $time, m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("value", want.value, m_tdata);
                compare_field("underflow", 32'(want.underflow), 32'(m_tuser[0]));
                compare_field("overflow", 32'(want.overflow), 32'(m_tuser[1]));
                compare_field("div_zero", 32'(want.div_zero), 32'(m_tuser[2]));
            end
        end
    end

    // Watchdog
    initial begin
        #6000000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/pef_pkg.sv
sv/pef_stack_ram.sv
sv/pef_divider.sv
sv/postfix_expression_evaluator.sv
sim/postfix_expression_evaluator_test.sv
